>>> rtl/sse_pkg.sv
// Shared types, constants and helpers for the substring search engine.
`default_nettype none
package sse_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int TEXT_MAX    = 65536;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int CNT_W       = POS_W + 1;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW     = 3'd0,
    CFG_PAT_HIGH    = 3'd1,
    CFG_PAT_LENGTH  = 3'd2,
    CFG_IGNORE_CASE = 3'd3,
    CFG_FIND_LAST   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } sse_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             overflow;
  } sse_out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low_bytes;
    logic [CFG_DATA_W-1:0] pattern_high_bytes;
    logic [LEN_W-1:0]      pattern_length;
    logic                  ignore_case;
    logic                  find_last;
  } sse_cfg_t;

  // Fold ASCII upper-case letters to lower case when enabled
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic            fold);
    logic [BYTE_W-1:0] r;
    r = b;
    if (fold && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/substring_search_engine_core.sv
// Top level of the streaming substring search engine.
//
// Text bytes enter on the in channel (in_valid / in_stall / in_data), one
// transfer per byte; end_of_text marks the last byte of a text. Only that
// last byte yields a transfer on the out channel: found, the start offset of
// the first (or, with find_last set, the last) match, and the overflow flag.
// The pattern, its length, case folding and find mode are written on the
// cfg channel (cfg_valid / cfg_ready, always ready); the user must write
// them only while the block is idle, and the block has no check for this.
// Throughput: one byte per cycle, except while a last byte waits for a
// stalled output register. The compare of all pattern bytes against the
// byte window is combinational, between the input register and the result
// register, which presents the result of a last byte on out_valid.
// While the receiver stalls, the result stays in the output register and
// non-last bytes keep flowing; a last byte waits in the input register and
// in_stall rises until the output register frees.
// Reset clears configuration, text state and both valid flags.
`default_nettype none
module substring_search_engine_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire sse_pkg::sse_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sse_pkg::sse_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sse_pkg::*;

  sse_cfg_t cfg;
  logic     res_valid;
  logic     res_block;
  sse_out_t res_data;

  sse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sse_matcher u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_block (res_block),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  sse_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_block (res_block),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/sse_cfg_regs.sv
// Configuration register file of the substring search engine.
`default_nettype none
module sse_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sse_pkg::sse_cfg_t                     cfg
);
  import sse_pkg::*;

  sse_cfg_t regs;
  logic     wr;

  // Always take writes
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Decode index and update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        CFG_PAT_LOW:     regs.pattern_low_bytes  <= cfg_data;
        CFG_PAT_HIGH:    regs.pattern_high_bytes <= cfg_data;
        CFG_PAT_LENGTH:  regs.pattern_length     <= cfg_data[LEN_W-1:0];
        CFG_IGNORE_CASE: regs.ignore_case        <= cfg_data[0];
        CFG_FIND_LAST:   regs.find_last          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

>>> rtl/sse_matcher.sv
// Input register, byte window, pattern compare and per-text match state.
`default_nettype none
module sse_matcher (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sse_pkg::sse_in_t  in_data,
  input  wire sse_pkg::sse_cfg_t cfg,
  input  wire logic              res_block,
  output logic                   res_valid,
  output sse_pkg::sse_out_t      res_data
);
  import sse_pkg::*;

  // Input register
  logic    s1_valid;
  sse_in_t s1_data;

  // Text state
  logic [BYTE_W-1:0] window [PATTERN_MAX];
  logic [CNT_W-1:0]  bytes_seen;
  logic              match_seen;
  logic [POS_W-1:0]  match_start;
  logic              overflow_seen;

  logic [BYTE_W-1:0] window_next [PATTERN_MAX];
  logic [CNT_W-1:0]  bytes_seen_next;
  logic              match_seen_next;
  logic [POS_W-1:0]  match_start_next;
  logic              overflow_seen_next;

  logic                         accept;
  logic                         advance;
  logic                         in_range;
  logic [BYTE_W-1:0]            shifted [PATTERN_MAX];
  logic [2*CFG_DATA_W-1:0]      pattern;
  logic [PATTERN_MAX-1:0]       byte_ok;
  logic                         len_ok;
  logic                         enough;
  logic                         hit;
  logic [CNT_W-1:0]             seen_plus;
  logic [CNT_W-1:0]             start_full;

  // A last byte waits while the result register is blocked
  assign advance  = s1_valid && (!s1_data.end_of_text || !res_block);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= in_data;
    end
  end

  // Shift the new byte into the window
  always_comb begin
    shifted[0] = s1_data.text_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      shifted[i] = window[i-1];
    end
  end

  // Compare pattern byte k with the window byte of age len-1-k
  assign pattern = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      logic [LEN_W-1:0] age;
      age = cfg.pattern_length - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) < cfg.pattern_length) begin
        byte_ok[k] = fold_byte(shifted[age[IDX_W-1:0]], cfg.ignore_case) ==
                     fold_byte(pattern[k*BYTE_W +: BYTE_W], cfg.ignore_case);
      end else begin
        byte_ok[k] = 1'b1;
      end
    end
  end

  assign in_range   = !bytes_seen[CNT_W-1];
  assign seen_plus  = bytes_seen + CNT_W'(1);
  assign len_ok     = cfg.pattern_length != '0 &&
                      cfg.pattern_length <= LEN_W'(PATTERN_MAX);
  assign enough     = seen_plus >= CNT_W'(cfg.pattern_length);
  assign hit        = len_ok && enough && (&byte_ok);
  assign start_full = seen_plus - CNT_W'(cfg.pattern_length);

  // Update the text state for the current byte
  always_comb begin
    window_next        = window;
    bytes_seen_next    = bytes_seen;
    match_seen_next    = match_seen;
    match_start_next   = match_start;
    overflow_seen_next = overflow_seen;
    if (!in_range) begin
      overflow_seen_next = 1'b1;
    end else begin
      window_next     = shifted;
      bytes_seen_next = seen_plus;
      if (hit && (!match_seen || cfg.find_last)) begin
        match_seen_next  = 1'b1;
        match_start_next = start_full[POS_W-1:0];
      end
    end
  end

  // Build the result from the updated state
  assign res_valid               = advance && s1_data.end_of_text;
  assign res_data.found          = match_seen_next;
  assign res_data.match_position = match_seen_next ? match_start_next : '0;
  assign res_data.overflow       = overflow_seen_next;

  // Hold the state, advance on each byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= '0;
      end
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      match_start   <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      if (s1_data.end_of_text) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          window[i] <= '0;
        end
        bytes_seen    <= '0;
        match_seen    <= 1'b0;
        match_start   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        window        <= window_next;
        bytes_seen    <= bytes_seen_next;
        match_seen    <= match_seen_next;
        match_start   <= match_start_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/sse_out_reg.sv
// Result output register of the substring search engine.
`default_nettype none
module sse_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               res_valid,
  input  wire sse_pkg::sse_out_t  res_data,
  output logic                    res_block,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sse_pkg::sse_out_t       out_data
);
  import sse_pkg::*;

  sse_out_t held;

  // Full and stalled: nothing new can enter
  assign res_block = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load a new result, hold while stalled
  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res_data;
    end
  end

  assign out_data = held;

endmodule
`default_nettype wire

>>> rtl/sse_checker.sv
// Port-level checks for the substring search engine, bound to the top level.
`default_nettype none
module sse_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire sse_pkg::sse_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sse_pkg::sse_out_t out_data
);
  import sse_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed or dropped");

  // No match means position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_position == '0)
    else $error("position set without a match");

  // Input backs up only behind a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // Nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind substring_search_engine_core sse_checker u_sse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
